// ----- src/lxd_pkg.sv -----
// Shared types, codes and constants of the keystream descrambler.
`default_nettype none
package lxd_pkg;

  localparam int unsigned SIG_LEN   = 14;
  localparam int unsigned EXTRA_LEN = 8;

  localparam logic [4:0]  HC_SIG_LAST   = 5'(SIG_LEN - 1);
  localparam logic [4:0]  HC_EXTRA_LAST = 5'(SIG_LEN + EXTRA_LEN - 1);

  localparam logic [23:0] LCG_MUL  = 24'hFD43FD;  // low 24 bits of 0x43FD43FD
  localparam logic [23:0] LCG_ADD  = 24'hC39EC3;
  localparam logic [23:0] LCG_SEED = 24'hA09E86;

  localparam logic [7:0]  CHAR_LF = 8'h0A;
  localparam logic [7:0]  CHAR_CR = 8'h0D;

  // Result kinds.
  localparam logic [1:0] KIND_DATA   = 2'd0;
  localparam logic [1:0] KIND_ACCEPT = 2'd1;
  localparam logic [1:0] KIND_REJECT = 2'd2;

  // File versions.
  localparam logic [1:0] VER_NONE = 2'd0;
  localparam logic [1:0] VER_40   = 2'd1;
  localparam logic [1:0] VER_39   = 2'd2;
  localparam logic [1:0] VER_38   = 2'd3;

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_EXTRA  = 2'd1,
    PH_DATA   = 2'd2,
    PH_DROP   = 2'd3
  } phase_t;

  typedef struct packed {
    logic       go;        // input transaction this cycle
    logic       clear;     // first byte of a new file
    phase_t     phase;     // phase that applies to this byte
    logic       emit;      // this byte produces a result
    logic [1:0] kind;
    logic       ver_wr;
    logic [1:0] ver_code;
  } ctl_cmd_t;

  typedef struct packed {
    logic       out_free;   // output register can take a result
    logic       sig_last;   // byte is the last signature byte
    logic       extra_last; // byte is the last extra header byte
    logic [2:0] match_nxt;  // signatures still matching after this byte
  } dp_status_t;

  // Signature byte of signature k (0: 4.0, 1: 3.9, 2: 3.8) at position idx.
  function automatic logic [7:0] sig_byte(input logic [1:0] k, input logic [3:0] idx);
    logic [7:0] b;
    unique case (idx)
      4'd0:    b = 8'h3C;
      4'd1:    b = 8'h42;
      4'd2:    b = 8'h3F;
      4'd3:    b = 8'hC9;
      4'd4:    b = 8'h6A;
      4'd5:    b = 8'h87;
      4'd6:    b = 8'hC2;
      4'd7:    b = 8'hCF;
      4'd8:    b = (k == 2'd0) ? 8'h93 : 8'h94;
      4'd9:    b = 8'h45;
      4'd10:   b = (k == 2'd0) ? 8'h3E : ((k == 2'd1) ? 8'h37 : 8'h36);
      4'd11:   b = 8'h61;
      4'd12:   b = 8'h39;
      4'd13:   b = 8'hFA;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage
`default_nettype wire

// ----- src/lxd_ctrl.sv -----
// Controller: file phase state machine, configuration register and handshake.
`default_nettype none
module lxd_ctrl
  import lxd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_we,
  input  wire logic       cfg_wdata,
  input  wire logic       in_tvalid,
  input  wire logic       first_byte,
  output      logic       in_tready,
  input  wire dp_status_t status,
  output      ctl_cmd_t   cmd
);

  logic   game_file_r;
  phase_t phase_r, phase_nxt;
  phase_t phase_eff;
  logic   go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      game_file_r <= 1'b1;
    end else if (cfg_we) begin
      game_file_r <= cfg_wdata;
    end
  end

  assign in_tready = status.out_free;
  assign go        = in_tvalid & status.out_free;
  assign phase_eff = (first_byte) ? (game_file_r ? PH_HEADER : PH_DATA) : phase_r;

  // Next state.
  always_comb begin
    phase_nxt = phase_r;
    if (go) begin
      phase_nxt = phase_eff;
      unique case (phase_eff)
        PH_HEADER: begin
          if (status.sig_last) begin
            priority if (status.match_nxt[0]) begin
              phase_nxt = PH_EXTRA;
            end else if (status.match_nxt[1] || status.match_nxt[2]) begin
              phase_nxt = PH_DATA;
            end else begin
              phase_nxt = PH_DROP;
            end
          end
        end
        PH_EXTRA: begin
          if (status.extra_last) begin
            phase_nxt = PH_DATA;
          end
        end
        PH_DATA:  phase_nxt = PH_DATA;
        PH_DROP:  phase_nxt = PH_DROP;
        default:  phase_nxt = phase_eff;
      endcase
    end
  end

  // Outputs.
  always_comb begin
    cmd          = '0;
    cmd.go       = go;
    cmd.clear    = first_byte;
    cmd.phase    = phase_eff;
    cmd.kind     = KIND_DATA;
    cmd.ver_wr   = first_byte;
    cmd.ver_code = game_file_r ? VER_NONE : VER_40;
    unique case (phase_eff)
      PH_HEADER: begin
        if (status.sig_last) begin
          cmd.ver_wr = 1'b1;
          priority if (status.match_nxt[0]) begin
            cmd.ver_code = VER_40;
          end else if (status.match_nxt[1]) begin
            cmd.ver_code = VER_39;
            cmd.emit     = 1'b1;
            cmd.kind     = KIND_ACCEPT;
          end else if (status.match_nxt[2]) begin
            cmd.ver_code = VER_38;
            cmd.emit     = 1'b1;
            cmd.kind     = KIND_ACCEPT;
          end else begin
            cmd.ver_code = VER_NONE;
            cmd.emit     = 1'b1;
            cmd.kind     = KIND_REJECT;
          end
        end
      end
      PH_EXTRA: begin
        if (status.extra_last) begin
          cmd.emit = 1'b1;
          cmd.kind = KIND_ACCEPT;
        end
      end
      PH_DATA:  cmd.emit = 1'b1;
      PH_DROP:  cmd.emit = 1'b0;
      default:  cmd.emit = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HEADER;
    end else begin
      phase_r <= phase_nxt;
    end
  end

  a_reject_drops: assert property (@(posedge clk) disable iff (!rst_n)
    (go && cmd.emit && cmd.kind == KIND_REJECT) |=> (phase_r == PH_DROP))
    else $error("reject result without entering the drop phase");

  a_drop_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (go && phase_r == PH_DROP && !first_byte) |-> !cmd.emit)
    else $error("result emitted from a dropped file");

endmodule
`default_nettype wire

// ----- src/lxd_dpath.sv -----
// Datapath: header counter, signature match, keystream generator and output register.
`default_nettype none
module lxd_dpath
  import lxd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire ctl_cmd_t   cmd,
  input  wire logic [7:0] in_byte,
  output      dp_status_t status,
  input  wire logic       out_tready,
  output      logic       out_valid,
  output      logic [7:0] out_byte,
  output      logic [1:0] out_kind,
  output      logic [1:0] out_version,
  output      logic       out_line_break
);

  logic [4:0]  hc_r, hc_nxt, hc_eff;
  logic [2:0]  match_r, match_eff, match_nxt;
  logic [23:0] lcg_r, lcg_eff, lcg_step, lcg_nxt;
  logic [1:0]  ver_r, ver_nxt;
  logic [31:0] key_prod;
  logic [7:0]  key;
  logic [7:0]  plain;
  logic        is_brk;
  logic        scrambled;
  logic        out_valid_r;
  logic [7:0]  byte_r, byte_nxt;
  logic [1:0]  kind_r, ver_out_r;
  logic        lb_r, lb_nxt;

  assign hc_eff    = cmd.clear ? 5'd0 : hc_r;
  assign match_eff = cmd.clear ? 3'b111 : match_r;
  assign lcg_eff   = cmd.clear ? LCG_SEED : lcg_r;
  assign ver_nxt   = cmd.ver_wr ? cmd.ver_code : ver_r;

  always_comb begin
    match_nxt = match_eff;
    for (int k = 0; k < 3; k++) begin
      if (sig_byte(2'(k), hc_eff[3:0]) != in_byte) begin
        match_nxt[k] = 1'b0;
      end
    end
  end

  // Keystream: next generator state and its key byte floor(255 * s / 2^24).
  assign lcg_step  = lcg_eff * LCG_MUL + LCG_ADD;
  assign key_prod  = {lcg_step, 8'h00} - {8'h00, lcg_step};
  assign key       = key_prod[31:24];
  assign plain     = in_byte ^ key;
  assign is_brk    = (plain == CHAR_LF) || (plain == CHAR_CR);
  assign scrambled = (ver_nxt == VER_39) || (ver_nxt == VER_38);

  always_comb begin
    hc_nxt  = hc_eff;
    lcg_nxt = lcg_eff;
    unique case (cmd.phase)
      PH_HEADER: begin
        hc_nxt  = hc_eff + 5'd1;
        lcg_nxt = lcg_step;
      end
      PH_EXTRA: hc_nxt = hc_eff + 5'd1;
      PH_DATA: begin
        if (scrambled) begin
          lcg_nxt = lcg_step;
        end
      end
      PH_DROP:  hc_nxt = hc_eff;
      default:  hc_nxt = hc_eff;
    endcase
  end

  always_comb begin
    byte_nxt = 8'h00;
    lb_nxt   = 1'b0;
    if (cmd.kind == KIND_DATA) begin
      if (scrambled) begin
        byte_nxt = is_brk ? 8'h00 : plain;
        lb_nxt   = is_brk;
      end else begin
        byte_nxt = in_byte;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hc_r        <= 5'd0;
      match_r     <= 3'b111;
      lcg_r       <= LCG_SEED;
      ver_r       <= VER_NONE;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.go) begin
        hc_r    <= (cmd.phase == PH_DATA || cmd.phase == PH_DROP) ? hc_eff : hc_nxt;
        match_r <= (cmd.phase == PH_HEADER) ? match_nxt : match_eff;
        lcg_r   <= lcg_nxt;
        ver_r   <= ver_nxt;
      end
      if (cmd.go && cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.go && cmd.emit) begin
      byte_r    <= byte_nxt;
      kind_r    <= cmd.kind;
      ver_out_r <= ver_nxt;
      lb_r      <= lb_nxt;
    end
  end

  assign status.out_free   = !out_valid_r || out_tready;
  assign status.sig_last   = (hc_eff == HC_SIG_LAST);
  assign status.extra_last = (hc_eff == HC_EXTRA_LAST);
  assign status.match_nxt  = match_nxt;

  assign out_valid      = out_valid_r;
  assign out_byte       = byte_r;
  assign out_kind       = kind_r;
  assign out_version    = ver_out_r;
  assign out_line_break = lb_r;

  a_brk_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && lb_r) |->
      (byte_r == 8'h00 && kind_r == KIND_DATA && (ver_out_r == VER_39 || ver_out_r == VER_38)))
    else $error("line break flagged on a non-zero or unscrambled byte");

  a_hc_range: assert property (@(posedge clk) disable iff (!rst_n)
    hc_r <= HC_EXTRA_LAST + 5'd1)
    else $error("header counter beyond the header length");

endmodule
`default_nettype wire

// ----- src/lcg_xor_descrambler_with_header_top.sv -----
// Top level of the header-checking keystream descrambler.
// A result appears on out_tvalid in the cycle after the input transaction that causes it.
// One byte per cycle unless out_tready stalls; the generator step (a 24-bit multiply) fits in it.
// The output register frees in the same cycle its transaction completes, so no bubble is added.
// Reset (rst_n low at a clock edge) selects game-file mode and starts a fresh file header.
`default_nettype none
module lcg_xor_descrambler_with_header_top
  import lxd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  // Configuration: bit 0 of cfg_wdata is game_file (1 = header present).
  input  wire logic       cfg_we,
  input  wire logic       cfg_wdata,
  // Input stream, one file byte per transaction.
  input  wire logic       in_tvalid,
  output      logic       in_tready,
  input  wire logic [7:0] in_tdata,   // [7:0] in_byte
  input  wire logic [0:0] in_tuser,   // [0] first_byte
  // Result stream.
  output      logic       out_tvalid,
  input  wire logic       out_tready,
  output      logic [7:0] out_tdata,  // [7:0] out_byte
  output      logic [4:0] out_tuser   // [1:0] result_kind, [3:2] file_version, [4] line_break
);

  ctl_cmd_t   cmd;
  dp_status_t status;
  logic [1:0] kind;
  logic [1:0] version;
  logic       line_break;

  // The controller tracks which part of the file a byte belongs to and decides when
  // a transaction yields a result; the datapath matches signatures, runs the keystream
  // generator and holds the outgoing result.
  lxd_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .first_byte (in_tuser[0]),
    .in_tready  (in_tready),
    .status     (status),
    .cmd        (cmd)
  );

  lxd_dpath u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .in_byte        (in_tdata),
    .status         (status),
    .out_tready     (out_tready),
    .out_valid      (out_tvalid),
    .out_byte       (out_tdata),
    .out_kind       (kind),
    .out_version    (version),
    .out_line_break (line_break)
  );

  assign out_tuser = {line_break, version, kind};

endmodule
`default_nettype wire

// ----- bench/testbench.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for the header-checking keystream descrambler.
module testbench;
  import lxd_pkg::*;

  // Clock, reset and run-length settings.
  localparam int CLK_HALF        = 6;
  localparam int RESET_CYCLES    = 6;
  localparam int DRAIN_CYCLES    = 4;
  localparam int CYCLE_LIMIT     = 500000;
  localparam int HOLD_OFF_CYCLES = 300;

  // Indexes of the three header signatures, in the order they are checked.
  localparam int SIG_IDX_40 = 0;
  localparam int SIG_IDX_39 = 1;
  localparam int SIG_IDX_38 = 2;

  // Each signature is packed with its first byte in the lowest bits.
  localparam logic [2:0][111:0] HDR_SIGS = {
    112'hFA3961364594CFC2876AC93F423C,  // version 3.8
    112'hFA3961374594CFC2876AC93F423C,  // version 3.9
    112'hFA39613E4593CFC2876AC93F423C   // version 4.0
  };

  // One expected result, with the fields of the result stream.
  typedef struct packed {
    logic [7:0] data;
    logic [1:0] kind;
    logic [1:0] ver;
    logic       brk;
  } descr_result_t;

  // Patterns that the result receiver cycles through when it is not held off.
  typedef enum logic [1:0] {
    RX_ALWAYS,
    RX_COIN,
    RX_ONE_IN_FOUR,
    RX_MOSTLY
  } rx_pattern_t;

  // Every input of the block starts at a known value.
  logic       clk        = 1'b0;
  logic       rst_n      = 1'b0;
  logic       cfg_we     = 1'b0;
  logic       cfg_wdata  = 1'b0;
  logic       in_tvalid  = 1'b0;
  logic [7:0] in_tdata   = 8'h00;
  logic [0:0] in_tuser   = 1'b0;
  logic       out_tready = 1'b0;
  logic       in_tready;
  logic       out_tvalid;
  logic [7:0] out_tdata;
  logic [4:0] out_tuser;

  // Shadow of the descrambler state, advanced once per accepted input transaction.
  logic       cfg_game_file;
  phase_t     file_phase;
  logic [4:0] hdr_count;
  logic [2:0] sig_alive;
  logic [23:0] lcg_q;
  logic [1:0] file_ver;

  // Results that the block still owes, oldest first.
  descr_result_t expected_results[$];

  int  live_bytes      = 0;  // accepted bytes that the block did not drop
  int  error_count     = 0;
  int  cycle_count     = 0;
  int  burst_left      = 0;
  bit  sender_no_gaps  = 1'b0;
  int  hold_cycles_req = 0;

  // Receiver state.
  rx_pattern_t rx_pattern = RX_ALWAYS;
  int rx_left   = 0;
  int hold_left = 0;
  int rx_tick   = 0;

  lcg_xor_descrambler_with_header_top u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // The start of a file clears everything; the mode register picks the first phase.
  task automatic restart_file();
    hdr_count = 5'd0;
    sig_alive = 3'b111;
    lcg_q     = LCG_SEED;
    if (cfg_game_file) begin
      file_phase = PH_HEADER;
      file_ver   = VER_NONE;
    end else begin
      file_phase = PH_DATA;
      file_ver   = VER_40;
    end
  endtask

  // One generator step, modulo 2^24.
  function automatic logic [23:0] lcg_next(input logic [23:0] s);
    return s * LCG_MUL + LCG_ADD;
  endfunction

  // The key byte is floor(255 * state / 2^24).
  function automatic logic [7:0] key_of(input logic [23:0] s);
    logic [31:0] p;
    p = {8'd0, s} * 32'd255;
    return p[31:24];
  endfunction

  // A raw byte that descrambles to the given value if the next byte is 3.9/3.8 data.
  function automatic logic [7:0] scrambled_as(input logic [7:0] plain);
    return key_of(lcg_next(lcg_q)) ^ plain;
  endfunction

  task automatic expect_result(input logic [7:0] d, input logic [1:0] k,
                               input logic [1:0] v, input logic b);
    expected_results.push_back('{data: d, kind: k, ver: v, brk: b});
  endtask

  // Advances the shadow state by one accepted byte and queues any result it causes.
  task automatic predict_descramble(input logic [7:0] b, input logic first);
    logic [7:0] d;
    int k;
    if (first) restart_file();
    if (file_phase != PH_DROP) live_bytes++;
    case (file_phase)
      PH_HEADER: begin
        for (k = 0; k < 3; k++) begin
          if (hdr_count < SIG_LEN && HDR_SIGS[k][8 * hdr_count +: 8] != b) sig_alive[k] = 1'b0;
        end
        lcg_q = lcg_next(lcg_q);
        hdr_count++;
        if (hdr_count >= SIG_LEN) begin
          // The 4.0 signature wins over 3.9, and 3.9 over 3.8.
          if (sig_alive[SIG_IDX_40]) begin
            file_ver   = VER_40;
            file_phase = PH_EXTRA;
          end else if (sig_alive[SIG_IDX_39]) begin
            file_ver   = VER_39;
            file_phase = PH_DATA;
            expect_result(8'h00, KIND_ACCEPT, file_ver, 1'b0);
          end else if (sig_alive[SIG_IDX_38]) begin
            file_ver   = VER_38;
            file_phase = PH_DATA;
            expect_result(8'h00, KIND_ACCEPT, file_ver, 1'b0);
          end else begin
            file_ver   = VER_NONE;
            file_phase = PH_DROP;
            expect_result(8'h00, KIND_REJECT, VER_NONE, 1'b0);
          end
        end
      end
      PH_EXTRA: begin
        hdr_count++;
        if (hdr_count >= SIG_LEN + EXTRA_LEN) begin
          file_phase = PH_DATA;
          expect_result(8'h00, KIND_ACCEPT, file_ver, 1'b0);
        end
      end
      PH_DATA: begin
        if (file_ver == VER_39 || file_ver == VER_38) begin
          lcg_q = lcg_next(lcg_q);
          d = b ^ key_of(lcg_q);
          if (d == CHAR_LF || d == CHAR_CR) expect_result(8'h00, KIND_DATA, file_ver, 1'b1);
          else expect_result(d, KIND_DATA, file_ver, 1'b0);
        end else begin
          expect_result(b, KIND_DATA, file_ver, 1'b0);
        end
      end
      default: ;
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------------

  // Offers one byte and waits for its transaction. The sender works in bursts of
  // random length; between bursts in_tvalid may drop for a random number of cycles.
  task automatic send_byte(input logic [7:0] b, input logic first);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0 || sender_no_gaps) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tuser  <= first;
    do @(posedge clk); while (!in_tready);
    predict_descramble(b, first);
  endtask

  // Random data byte, biased toward the line-break bytes and the extremes.
  function automatic logic [7:0] rand_data_byte();
    case ($urandom_range(0, 15))
      0:       return scrambled_as(CHAR_LF);
      1:       return scrambled_as(CHAR_CR);
      2:       return 8'h00;
      3:       return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Sends the first len bytes of a header; bytes past the signature are the
  // 4.0 extra bytes and carry random content. One byte may be corrupted.
  task automatic send_header(input int sig, input int len, input bit corrupt);
    logic [7:0] b;
    int bad;
    int i;
    bad = $urandom_range(0, SIG_LEN - 1);
    for (i = 0; i < len; i++) begin
      if (i < SIG_LEN) b = HDR_SIGS[sig][8 * i +: 8];
      else b = 8'($urandom_range(0, 255));
      if (corrupt && i == bad) b = b ^ 8'($urandom_range(1, 255));
      send_byte(b, i == 0);
    end
  endtask

  task automatic send_data(input int n);
    repeat (n) send_byte(rand_data_byte(), 1'b0);
  endtask

  // Data runs are mostly short, with an occasional long one.
  function automatic int data_len();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120) : $urandom_range(0, 24);
  endfunction

  // One file of a random shape. Most are well formed so that the data phase is
  // reached; the rest are corrupted, truncated or pure noise.
  task automatic send_random_file();
    int shape;
    int sig;
    int i;
    if (!cfg_game_file) begin
      send_byte(rand_data_byte(), 1'b1);
      send_data(data_len());
    end else begin
      shape = $urandom_range(0, 99);
      sig   = $urandom_range(SIG_IDX_40, SIG_IDX_38);
      if (shape < 30) begin
        send_header(($urandom_range(0, 1) != 0) ? SIG_IDX_39 : SIG_IDX_38, SIG_LEN, 1'b0);
        send_data(data_len());
      end else if (shape < 55) begin
        send_header(SIG_IDX_40, SIG_LEN + EXTRA_LEN, 1'b0);
        send_data(data_len());
      end else if (shape < 70) begin
        send_header(sig, (sig == SIG_IDX_40) ? SIG_LEN + EXTRA_LEN : SIG_LEN, 1'b1);
        send_data(data_len());
      end else if (shape < 82) begin
        // The file ends inside its header; the next file start cuts it off.
        send_header(sig, $urandom_range(1, ((sig == SIG_IDX_40) ? SIG_LEN + EXTRA_LEN :
                                            SIG_LEN) - 1), 1'b0);
      end else begin
        for (i = 0; i < SIG_LEN; i++) send_byte(8'($urandom_range(0, 255)), i == 0);
        send_data($urandom_range(0, 12));
      end
    end
  endtask

  task automatic run_random_files(input int target);
    int goal;
    goal = live_bytes + target;
    while (live_bytes < goal) send_random_file();
  endtask

  // Stops offering input and waits until every expected result has arrived, plus
  // a few cycles for a header byte that is still on its way through.
  task automatic drain_results();
    in_tvalid  <= 1'b0;
    burst_left = 0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // The mode register is only written while the block is idle.
  task automatic set_game_file(input logic v);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    cfg_game_file = v;
  endtask

  // ---------------------------------------------------------------------------
  // Output side
  // ---------------------------------------------------------------------------

  // The receiver runs its own stall pattern and honors a long hold-off on request.
  always @(posedge clk) begin
    rx_tick++;
    if (hold_cycles_req != 0) begin
      hold_left = hold_cycles_req;
      hold_cycles_req = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      if (rx_left == 0) begin
        rx_pattern = rx_pattern_t'($urandom_range(0, 3));
        rx_left    = $urandom_range(16, 96);
      end
      rx_left--;
      case (rx_pattern)
        RX_ALWAYS:      out_tready <= 1'b1;
        RX_COIN:        out_tready <= 1'($urandom_range(0, 1));
        RX_ONE_IN_FOUR: out_tready <= (rx_tick % 4 == 0);
        default:        out_tready <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $time, msg);
    error_count++;
  endtask

  // Every result transaction is compared field by field with the oldest expectation.
  always @(posedge clk) begin
    descr_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result tdata=%h tuser=%h", out_tdata, out_tuser));
      end else begin
        want = expected_results.pop_front();
        if (out_tdata !== want.data)
          report_mismatch($sformatf("out_byte %h, expected %h", out_tdata, want.data));
        if (out_tuser[1:0] !== want.kind)
          report_mismatch($sformatf("result_kind %0d, expected %0d", out_tuser[1:0], want.kind));
        if (out_tuser[3:2] !== want.ver)
          report_mismatch($sformatf("file_version %0d, expected %0d", out_tuser[3:2], want.ver));
        if (out_tuser[4] !== want.brk)
          report_mismatch($sformatf("line_break %0d, expected %0d", out_tuser[4], want.brk));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // A 3.8 header right after reset, then data that descrambles to LF and CR and
  // the two extreme raw values.
  task automatic test_v38_after_reset();
    send_header(SIG_IDX_38, SIG_LEN, 1'b0);
    send_byte(scrambled_as(CHAR_LF), 1'b0);
    send_byte(scrambled_as(CHAR_CR), 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
  endtask

  // A header cut short gives no result; the next file start begins afresh.
  task automatic test_truncated_header();
    send_header(SIG_IDX_39, 5, 1'b0);
  endtask

  task automatic test_game_files();
    run_random_files(300);
  endtask

  task automatic test_saved_files();
    set_game_file(1'b0);
    run_random_files(200);
  endtask

  // A mode change in the middle of a file must wait for the next file start.
  task automatic test_mode_change_mid_file();
    set_game_file(1'b1);
    send_header(SIG_IDX_39, SIG_LEN, 1'b0);
    send_data(6);
    set_game_file(1'b0);
    send_data(6);
    send_byte(rand_data_byte(), 1'b1);
    send_data(6);
    set_game_file(1'b1);
    send_data(6);
    send_header(SIG_IDX_38, SIG_LEN, 1'b0);
    send_data(4);
  endtask

  // The receiver holds off for a long stretch while the sender keeps offering
  // bytes back to back, so the output fills and the input stalls.
  task automatic test_output_hold_off();
    sender_no_gaps  = 1'b1;
    hold_cycles_req = HOLD_OFF_CYCLES;
    send_header(SIG_IDX_39, SIG_LEN, 1'b0);
    send_data(150);
    sender_no_gaps = 1'b0;
  endtask

  task automatic test_mixed_modes();
    repeat (4) begin
      set_game_file(1'($urandom_range(0, 1)));
      run_random_files(60);
    end
  endtask

  // Cycle counter that ends a run that hangs.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Verification failed");
    $finish;
  end

  initial begin
    cfg_game_file = 1'b1;
    restart_file();
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_v38_after_reset();
    test_truncated_header();
    test_game_files();
    test_saved_files();
    test_mode_change_mid_file();
    test_output_hold_off();
    test_mixed_modes();

    drain_results();
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ----- lcg_xor_descrambler_with_header_top.f -----
src/lxd_pkg.sv
src/lxd_ctrl.sv
src/lxd_dpath.sv
src/lcg_xor_descrambler_with_header_top.sv
bench/testbench.sv
